@@ rtl/core/cal4_pkg.sv @@
// Package of the four-digit calculator controller: key codes, digit codes,
// operation and state types, and the seven-segment table. No dependencies.
package cal4_pkg;

	localparam int unsigned DIG_W   = 5;
	localparam int unsigned KEY_W   = 5;
	localparam int unsigned SEG_W   = 8;
	localparam int unsigned OPND_W  = 15;
	localparam int unsigned PROD_W  = 2 * OPND_W;
	localparam int unsigned BIN_W   = 14;
	localparam int unsigned BCD_W   = 16;
	localparam int unsigned NDIG    = 4;

	// Digit codes.
	localparam logic [DIG_W-1:0] CODE_ZERO  = 5'd0;
	localparam logic [DIG_W-1:0] CODE_MINUS = 5'd16;
	localparam logic [DIG_W-1:0] CODE_BLANK = 5'd17;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_NINE   = 5'd9;
	localparam logic [KEY_W-1:0] KEY_CLEAR  = 5'd10;
	localparam logic [KEY_W-1:0] KEY_ZERO   = 5'd11;
	localparam logic [KEY_W-1:0] KEY_EQUALS = 5'd12;
	localparam logic [KEY_W-1:0] KEY_ADD    = 5'd13;
	localparam logic [KEY_W-1:0] KEY_DIV    = 5'd16;

	// Largest magnitudes that can be shown.
	localparam logic [PROD_W-1:0] MAX_POS = 30'd9999;
	localparam logic [PROD_W-1:0] MAX_NEG = 30'd999;

	// Index of the last iteration of each serial unit.
	localparam logic [3:0] ALU_LAST = 4'd14;
	localparam logic [3:0] BCD_LAST = 4'd13;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_CALC,
		ST_RANGE,
		ST_CONV,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic start;
		logic divide;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] result;
	} alu_rsp_t;

	// Seven-segment pattern of a digit code, bit 0 is segment a.
	function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] code);
		logic [SEG_W-1:0] s;
		case (code)
			5'd0:    s = 8'h3F;
			5'd1:    s = 8'h06;
			5'd2:    s = 8'h5B;
			5'd3:    s = 8'h4F;
			5'd4:    s = 8'h66;
			5'd5:    s = 8'h6D;
			5'd6:    s = 8'h7D;
			5'd7:    s = 8'h07;
			5'd8:    s = 8'h7F;
			5'd9:    s = 8'h67;
			5'd10:   s = 8'h77;
			5'd11:   s = 8'h7C;
			5'd12:   s = 8'h39;
			5'd13:   s = 8'h5E;
			5'd14:   s = 8'h79;
			5'd15:   s = 8'h71;
			5'd16:   s = 8'h40;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/core/cal4_if.sv @@
// Handshake channels of the calculator controller: key requests in and
// display requests out. Depends on cal4_pkg.
interface cal4_key_if;
	logic                         valid;
	logic                         ready;
	logic [cal4_pkg::KEY_W-1:0]   key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

interface cal4_disp_if;
	logic                         valid;
	logic                         ready;
	logic [cal4_pkg::DIG_W-1:0]   digit_units;
	logic [cal4_pkg::DIG_W-1:0]   digit_tens;
	logic [cal4_pkg::DIG_W-1:0]   digit_hundreds;
	logic [cal4_pkg::DIG_W-1:0]   digit_thousands;
	logic [cal4_pkg::SEG_W-1:0]   segments_units;
	logic [cal4_pkg::SEG_W-1:0]   segments_tens;
	logic [cal4_pkg::SEG_W-1:0]   segments_hundreds;
	logic [cal4_pkg::SEG_W-1:0]   segments_thousands;
	logic                         divide_by_zero;

	modport source (output valid, output digit_units, output digit_tens,
		output digit_hundreds, output digit_thousands, output segments_units,
		output segments_tens, output segments_hundreds, output segments_thousands,
		output divide_by_zero, input ready);
	modport sink (input valid, input digit_units, input digit_tens,
		input digit_hundreds, input digit_thousands, input segments_units,
		input segments_tens, input segments_hundreds, input segments_thousands,
		input divide_by_zero, output ready);
endinterface

@@ rtl/core/cal4_alu.sv @@
// Bit-serial multiplier and restoring divider for 15-bit operands, one bit
// per cycle. Depends on cal4_pkg.
module cal4_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cal4_pkg::alu_req_t            req,
	input  logic [cal4_pkg::OPND_W-1:0]   a,
	input  logic [cal4_pkg::OPND_W-1:0]   b,
	output cal4_pkg::alu_rsp_t            rsp
);

	logic                          busy_q;
	logic                          div_q;
	logic                          done_q;
	logic [3:0]                    cnt_q;
	logic [cal4_pkg::OPND_W-1:0]   hi_q;
	logic [cal4_pkg::OPND_W-1:0]   lo_q;
	logic [cal4_pkg::OPND_W:0]     mul_sum;
	logic [cal4_pkg::OPND_W:0]     trial;
	logic                          fits;
	logic [cal4_pkg::OPND_W-1:0]   hi_d;
	logic [cal4_pkg::OPND_W-1:0]   lo_d;

	// One step: add-and-shift for multiply, trial subtract for divide.
	always_comb begin
		mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b} : '0);
		trial   = {hi_q, lo_q[cal4_pkg::OPND_W-1]};
		fits    = (trial >= {1'b0, b});
		if (div_q) begin
			hi_d = fits ? cal4_pkg::OPND_W'(trial - {1'b0, b}) : trial[cal4_pkg::OPND_W-1:0];
			lo_d = {lo_q[cal4_pkg::OPND_W-2:0], fits};
		end else begin
			hi_d = mul_sum[cal4_pkg::OPND_W:1];
			lo_d = {mul_sum[0], lo_q[cal4_pkg::OPND_W-1:1]};
		end
	end

	// Control: counter and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == cal4_pkg::ALU_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divide;
			hi_q  <= '0;
			lo_q  <= a;
		end else if (busy_q) begin
			hi_q <= hi_d;
			lo_q <= lo_d;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = div_q ? {{cal4_pkg::OPND_W{1'b0}}, lo_q} : {hi_q, lo_q};

endmodule

@@ rtl/core/cal4_bcd.sv @@
// Serial binary to decimal converter (shift and add three), one bit per
// cycle. Depends on cal4_pkg.
module cal4_bcd (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cal4_pkg::BIN_W-1:0]   bin,
	output logic                         done,
	output logic [cal4_pkg::BCD_W-1:0]   bcd
);

	logic                         busy_q;
	logic                         done_q;
	logic [3:0]                   cnt_q;
	logic [cal4_pkg::BIN_W-1:0]   bin_q;
	logic [cal4_pkg::BCD_W-1:0]   bcd_q;
	logic [cal4_pkg::BCD_W-1:0]   adj;

	// Add three to every nibble of five or more before the shift.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == cal4_pkg::BCD_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[cal4_pkg::BIN_W-2:0], 1'b0};
			bcd_q <= {adj[cal4_pkg::BCD_W-2:0], bin_q[cal4_pkg::BIN_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

@@ rtl/core/four_digit_calculator_controller_core.sv @@
// Top level of the four-digit calculator controller: key sequencer, display
// state, output register. Depends on cal4_pkg, cal4_if, cal4_alu, cal4_bcd.
//
//   channel  | direction | payload
//   keys     | in        | key_code
//   display  | out       | four digit codes, four segment patterns, divide_by_zero
//
// Digit, clear, unused and unarmed equals keys go from the read state to the load.
// Operator keys read the display one digit per cycle, store the operand and load.
// Add and subtract read, evaluate, test the range, convert and load; multiply and
// divide run the serial unit before the range test. Division by zero shows 0.
// Reset shows 0 and clears the operand, operation and entry flags.
// A new key is taken while the previous display request still waits; a key that
// finishes while the output register is full holds until it drains.
module four_digit_calculator_controller_core (
	input  logic              clk,
	input  logic              arst_n,
	cal4_key_if.sink          keys,
	cal4_disp_if.source       display
);

	cal4_pkg::state_t              state_q, state_d;
	logic [cal4_pkg::DIG_W-1:0]    dig_q [cal4_pkg::NDIG];
	logic [cal4_pkg::OPND_W-1:0]   opnd_q;
	cal4_pkg::op_t                 op_q;
	logic                          starting_q;
	logic                          armed_q;
	logic [cal4_pkg::KEY_W-1:0]    key_q;
	logic [1:0]                    rd_idx_q;
	logic [cal4_pkg::OPND_W-1:0]   acc_q;
	logic                          div0_q;
	logic                          neg_q;
	logic [cal4_pkg::PROD_W-1:0]   mag_q;

	logic                          out_valid_q;
	logic [cal4_pkg::DIG_W-1:0]    out_dig_q [cal4_pkg::NDIG];
	logic [cal4_pkg::SEG_W-1:0]    out_seg_q [cal4_pkg::NDIG];
	logic                          out_div0_q;

	logic                          accept;
	logic                          load_out;
	logic                          is_digit;
	logic                          is_oper;
	logic                          in_range;
	logic [cal4_pkg::NDIG-1:0]     ok_vec;
	logic [cal4_pkg::DIG_W-1:0]    rd_dig;
	logic [cal4_pkg::OPND_W+2:0]   acc10;
	logic [cal4_pkg::OPND_W:0]     sum16;
	logic [cal4_pkg::OPND_W:0]     diff16;
	cal4_pkg::alu_req_t            alu_req;
	cal4_pkg::alu_rsp_t            alu_rsp;
	logic                          bcd_start;
	logic                          bcd_done;
	logic [cal4_pkg::BCD_W-1:0]    bcd;

	// Key decoding.
	assign is_digit = ((key_q != '0) && (key_q <= cal4_pkg::KEY_NINE))
		|| (key_q == cal4_pkg::KEY_ZERO);
	assign is_oper  = (key_q >= cal4_pkg::KEY_ADD) && (key_q <= cal4_pkg::KEY_DIV);

	// A digit counts toward the value only if no blank lies at or below it.
	always_comb begin
		ok_vec[0] = (dig_q[0] != cal4_pkg::CODE_BLANK);
		for (int i = 1; i < cal4_pkg::NDIG; i++) begin
			ok_vec[i] = ok_vec[i-1] && (dig_q[i] != cal4_pkg::CODE_BLANK);
		end
	end

	// Horner step of the display read, one digit per cycle from the top.
	assign rd_dig = dig_q[rd_idx_q];
	assign acc10  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};

	// Add and subtract of the operands.
	assign sum16  = {1'b0, opnd_q} + {1'b0, acc_q};
	assign diff16 = {1'b0, opnd_q} - {1'b0, acc_q};

	// Range test of the result magnitude.
	assign in_range = (mag_q != '0) && (neg_q ? (mag_q <= cal4_pkg::MAX_NEG)
		: (mag_q <= cal4_pkg::MAX_POS));

	// Next state and strobes.
	always_comb begin
		state_d        = state_q;
		alu_req.start  = 1'b0;
		alu_req.divide = (op_q == cal4_pkg::OP_DIV);
		bcd_start      = 1'b0;
		load_out       = 1'b0;
		case (state_q)
			cal4_pkg::ST_IDLE: begin
				if (keys.valid) begin
					state_d = cal4_pkg::ST_READ;
				end
			end
			cal4_pkg::ST_READ: begin
				if (!is_oper && !(key_q == cal4_pkg::KEY_EQUALS && armed_q)) begin
					state_d = cal4_pkg::ST_PUSH;
				end else if (rd_idx_q == 2'd0) begin
					state_d = cal4_pkg::ST_EVAL;
				end
			end
			cal4_pkg::ST_EVAL: begin
				if (is_oper) begin
					state_d = cal4_pkg::ST_PUSH;
				end else begin
					case (op_q)
						cal4_pkg::OP_ADD, cal4_pkg::OP_SUB: state_d = cal4_pkg::ST_RANGE;
						cal4_pkg::OP_MUL: begin
							alu_req.start = 1'b1;
							state_d       = cal4_pkg::ST_CALC;
						end
						cal4_pkg::OP_DIV: begin
							if (acc_q == '0) begin
								state_d = cal4_pkg::ST_PUSH;
							end else begin
								alu_req.start = 1'b1;
								state_d       = cal4_pkg::ST_CALC;
							end
						end
						default: state_d = cal4_pkg::ST_PUSH;
					endcase
				end
			end
			cal4_pkg::ST_CALC: begin
				if (alu_rsp.done) begin
					state_d = cal4_pkg::ST_RANGE;
				end
			end
			cal4_pkg::ST_RANGE: begin
				if (in_range) begin
					bcd_start = 1'b1;
					state_d   = cal4_pkg::ST_CONV;
				end else begin
					state_d = cal4_pkg::ST_PUSH;
				end
			end
			cal4_pkg::ST_CONV: begin
				if (bcd_done) begin
					state_d = cal4_pkg::ST_PUSH;
				end
			end
			cal4_pkg::ST_PUSH: begin
				if (!out_valid_q || display.ready) begin
					load_out = 1'b1;
					state_d  = cal4_pkg::ST_IDLE;
				end
			end
			default: state_d = cal4_pkg::ST_IDLE;
		endcase
	end

	assign keys.ready = (state_q == cal4_pkg::ST_IDLE);
	assign accept     = keys.valid && keys.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cal4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Calculator state: display digits, operand, operation, entry flags and divide-by-zero flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q[0]   <= cal4_pkg::CODE_ZERO;
			dig_q[1]   <= cal4_pkg::CODE_BLANK;
			dig_q[2]   <= cal4_pkg::CODE_BLANK;
			dig_q[3]   <= cal4_pkg::CODE_BLANK;
			opnd_q     <= '0;
			op_q       <= cal4_pkg::OP_NONE;
			starting_q <= 1'b1;
			armed_q    <= 1'b0;
			div0_q     <= 1'b0;
		end else begin
			case (state_q)
				cal4_pkg::ST_IDLE: begin
					if (accept) begin
						div0_q <= 1'b0;
					end
				end
				cal4_pkg::ST_READ: begin
					if (key_q == cal4_pkg::KEY_CLEAR || (is_digit
						&& dig_q[3] != cal4_pkg::CODE_BLANK)) begin
						dig_q[0]   <= cal4_pkg::CODE_ZERO;
						dig_q[1]   <= cal4_pkg::CODE_BLANK;
						dig_q[2]   <= cal4_pkg::CODE_BLANK;
						dig_q[3]   <= cal4_pkg::CODE_BLANK;
						opnd_q     <= '0;
						op_q       <= cal4_pkg::OP_NONE;
						starting_q <= 1'b1;
						armed_q    <= 1'b0;
					end else if (is_digit) begin
						dig_q[3] <= dig_q[2];
						dig_q[2] <= dig_q[1];
						dig_q[1] <= starting_q ? cal4_pkg::CODE_BLANK : dig_q[0];
						dig_q[0] <= (key_q == cal4_pkg::KEY_ZERO) ? cal4_pkg::CODE_ZERO
							: key_q;
						if (key_q != cal4_pkg::KEY_ZERO) begin
							starting_q <= 1'b0;
						end
					end
				end
				cal4_pkg::ST_EVAL: begin
					if (is_oper) begin
						op_q       <= cal4_pkg::op_t'(3'(key_q - cal4_pkg::KEY_EQUALS));
						opnd_q     <= acc_q;
						armed_q    <= 1'b1;
						starting_q <= 1'b1;
						dig_q[0]   <= cal4_pkg::CODE_ZERO;
						dig_q[1]   <= cal4_pkg::CODE_BLANK;
						dig_q[2]   <= cal4_pkg::CODE_BLANK;
						dig_q[3]   <= cal4_pkg::CODE_BLANK;
					end else if (op_q != cal4_pkg::OP_ADD && op_q != cal4_pkg::OP_SUB
						&& op_q != cal4_pkg::OP_MUL
						&& !(op_q == cal4_pkg::OP_DIV && acc_q != '0)) begin
						// No operation, or division by zero: show 0.
						div0_q     <= (op_q == cal4_pkg::OP_DIV);
						dig_q[0]   <= cal4_pkg::CODE_ZERO;
						dig_q[1]   <= cal4_pkg::CODE_BLANK;
						dig_q[2]   <= cal4_pkg::CODE_BLANK;
						dig_q[3]   <= cal4_pkg::CODE_BLANK;
						opnd_q     <= '0;
						op_q       <= cal4_pkg::OP_NONE;
						starting_q <= 1'b1;
						armed_q    <= 1'b0;
					end
				end
				cal4_pkg::ST_RANGE: begin
					if (!in_range) begin
						dig_q[0]   <= cal4_pkg::CODE_ZERO;
						dig_q[1]   <= cal4_pkg::CODE_BLANK;
						dig_q[2]   <= cal4_pkg::CODE_BLANK;
						dig_q[3]   <= cal4_pkg::CODE_BLANK;
						opnd_q     <= '0;
						op_q       <= cal4_pkg::OP_NONE;
						starting_q <= 1'b1;
						armed_q    <= 1'b0;
					end
				end
				cal4_pkg::ST_CONV: begin
					if (bcd_done) begin
						// Leading zeros blank, minus just above the top digit.
						for (int i = 0; i < cal4_pkg::NDIG; i++) begin
							if (i == 0 || (bcd >> (4 * i)) != '0) begin
								dig_q[i] <= {1'b0, bcd[4*i +: 4]};
							end else if (neg_q && (bcd >> (4 * (i - 1))) != '0) begin
								dig_q[i] <= cal4_pkg::CODE_MINUS;
							end else begin
								dig_q[i] <= cal4_pkg::CODE_BLANK;
							end
						end
						opnd_q     <= '0;
						op_q       <= cal4_pkg::OP_NONE;
						starting_q <= 1'b1;
						armed_q    <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers: key, display read and result magnitude.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= keys.key_code;
			rd_idx_q <= 2'd3;
			acc_q    <= '0;
		end
		if (state_q == cal4_pkg::ST_READ) begin
			rd_idx_q <= rd_idx_q - 2'd1;
			if (ok_vec[rd_idx_q]) begin
				acc_q <= cal4_pkg::OPND_W'(acc10) + {{(cal4_pkg::OPND_W-cal4_pkg::DIG_W){1'b0}},
					rd_dig};
			end
		end
		if (state_q == cal4_pkg::ST_EVAL) begin
			neg_q <= (op_q == cal4_pkg::OP_SUB) && diff16[cal4_pkg::OPND_W];
			if (op_q == cal4_pkg::OP_SUB) begin
				mag_q <= cal4_pkg::PROD_W'(diff16[cal4_pkg::OPND_W]
					? (acc_q - opnd_q) : diff16[cal4_pkg::OPND_W-1:0]);
			end else begin
				mag_q <= cal4_pkg::PROD_W'(sum16);
			end
		end
		if (state_q == cal4_pkg::ST_CALC && alu_rsp.done) begin
			mag_q <= alu_rsp.result;
		end
	end

	cal4_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opnd_q),
		.b      (acc_q),
		.rsp    (alu_rsp)
	);

	cal4_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (mag_q[cal4_pkg::BIN_W-1:0]),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// Output register: holds one display request until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (display.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < cal4_pkg::NDIG; i++) begin
				out_dig_q[i] <= dig_q[i];
				out_seg_q[i] <= cal4_pkg::seg_of(dig_q[i]);
			end
			out_div0_q <= div0_q;
		end
	end

	assign display.valid              = out_valid_q;
	assign display.digit_units        = out_dig_q[0];
	assign display.digit_tens         = out_dig_q[1];
	assign display.digit_hundreds     = out_dig_q[2];
	assign display.digit_thousands    = out_dig_q[3];
	assign display.segments_units     = out_seg_q[0];
	assign display.segments_tens      = out_seg_q[1];
	assign display.segments_hundreds  = out_seg_q[2];
	assign display.segments_thousands = out_seg_q[3];
	assign display.divide_by_zero     = out_div0_q;

`ifndef SYNTHESIS
	// An armed calculator always has an operation stored.
	a_armed_op: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> op_q != cal4_pkg::OP_NONE)
		else $error("armed without operation");

	// The serial units finish only while the sequencer waits for them.
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == cal4_pkg::ST_CALC)
		else $error("multiply or divide finished out of turn");

	a_bcd_done: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_done |-> state_q == cal4_pkg::ST_CONV)
		else $error("conversion finished out of turn");

	// A division by zero always shows a plain 0.
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_div0_q |-> out_dig_q[0] == cal4_pkg::CODE_ZERO
		&& out_dig_q[3] == cal4_pkg::CODE_BLANK)
		else $error("divide by zero without zero display");

	// A loaded request returns the sequencer to idle.
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> state_q == cal4_pkg::ST_IDLE && out_valid_q)
		else $error("request load did not complete");
`endif

endmodule
